>>> design/ctc_pkg.sv
// Shared types, constants and lookup functions for the C token classifier.
// Holds the keyword table, character classes and the front-to-back event record.
// No dependencies.
package ctc_pkg;

    localparam int COLUMN_LIMIT  = 1024;
    localparam int LENGTH_LIMIT  = 255;
    localparam int KW_CHARS      = 8;
    localparam int KW_COUNT      = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam int COL_W     = 10;
    localparam int LEN_W     = 8;
    localparam int KW_NUM_W  = 5;
    localparam int KW_IDX_W  = $clog2(KW_CHARS);
    localparam int CHAR_W    = 8;
    localparam int Q_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int M_DATA_W  = 32;

    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        KIND_OPERATOR   = 3'd0,
        KIND_KEYWORD    = 3'd1,
        KIND_INTEGER    = 3'd2,
        KIND_REAL       = 3'd3,
        KIND_IDENTIFIER = 3'd4,
        KIND_INVALID    = 3'd5
    } kind_t;

    typedef logic [KW_CHARS-1:0][CHAR_W-1:0] kw_chars_t;

    typedef struct packed {
        logic               has_tok;
        kind_t              tok_kind;
        logic [COL_W-1:0]   tok_start;
        logic [LEN_W-1:0]   tok_len;
        logic [KW_NUM_W-1:0] tok_kw;
        logic               has_op;
        logic [CHAR_W-1:0]  op_char;
        logic [COL_W-1:0]   op_col;
    } event_t;

    function automatic logic is_op(input logic [CHAR_W-1:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
               c == CH_GT || c == CH_LT || c == CH_EQ;
    endfunction

    function automatic logic is_delim(input logic [CHAR_W-1:0] c);
        return is_op(c) || c == CH_SPACE || c == CH_COMMA || c == CH_SEMI ||
               c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK ||
               c == CH_RBRACK || c == CH_LBRACE || c == CH_RBRACE;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [KW_CHARS*CHAR_W-1:0] kw_literal(input int idx);
        logic [KW_CHARS*CHAR_W-1:0] lit;
        case (idx)
            0:  lit = 64'("auto");
            1:  lit = 64'("break");
            2:  lit = 64'("case");
            3:  lit = 64'("char");
            4:  lit = 64'("const");
            5:  lit = 64'("continue");
            6:  lit = 64'("default");
            7:  lit = 64'("do");
            8:  lit = 64'("double");
            9:  lit = 64'("else");
            10: lit = 64'("enum");
            11: lit = 64'("extern");
            12: lit = 64'("float");
            13: lit = 64'("for");
            14: lit = 64'("goto");
            15: lit = 64'("if");
            16: lit = 64'("int");
            17: lit = 64'("long");
            18: lit = 64'("register");
            19: lit = 64'("return");
            20: lit = 64'("short");
            21: lit = 64'("signed");
            22: lit = 64'("sizeof");
            23: lit = 64'("static");
            24: lit = 64'("struct");
            25: lit = 64'("switch");
            26: lit = 64'("typedef");
            27: lit = 64'("union");
            28: lit = 64'("unsigned");
            29: lit = 64'("void");
            30: lit = 64'("volatile");
            31: lit = 64'("while");
            default: lit = '0;
        endcase
        return lit;
    endfunction

    function automatic logic [LEN_W-1:0] kw_len(input int idx);
        logic [KW_CHARS*CHAR_W-1:0] lit;
        int n;
        lit = kw_literal(idx);
        n = 0;
        for (int i = 0; i < KW_CHARS; i++) begin
            if (lit[CHAR_W*i +: CHAR_W] != '0) begin
                n = i + 1;
            end
        end
        return LEN_W'(n);
    endfunction

    function automatic kw_chars_t kw_text(input int idx);
        logic [KW_CHARS*CHAR_W-1:0] lit;
        kw_chars_t txt;
        int n;
        lit = kw_literal(idx);
        n = int'(kw_len(idx));
        txt = '0;
        for (int i = 0; i < KW_CHARS; i++) begin
            if (i < n) begin
                txt[i] = lit[CHAR_W*(n-1-i) +: CHAR_W];
            end
        end
        return txt;
    endfunction

endpackage

>>> design/ctc_front.sv
// Front end: accepts text bytes, gathers the pending token and classifies it.
// Produces one event record per byte that causes results. Depends on ctc_pkg.
module ctc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ctc_pkg::CHAR_W-1:0]   s_tdata,
    input  logic                         s_tlast,
    input  logic                         q_full,
    output logic                         q_push,
    output ctc_pkg::event_t              q_event
);

    ctc_pkg::kw_chars_t              chars_reg, chars_next, chars_upd, chars_aft;
    logic [ctc_pkg::LEN_W-1:0]       len_reg, len_next, len_upd, len_aft;
    logic [ctc_pkg::COL_W-1:0]       start_reg, start_next, start_upd, start_aft;
    logic [ctc_pkg::COL_W-1:0]       col_reg, col_next;
    logic                            all_dig_reg, all_dig_next, all_dig_upd, all_dig_aft;
    logic                            dod_reg, dod_next, dod_upd, dod_aft;
    logic                            dot_reg, dot_next, dot_upd, dot_aft;
    logic                            first_dig_reg, first_dig_next, first_dig_upd, first_dig_aft;
    logic                            accept, delim, digit, kw_hit;
    logic [ctc_pkg::KW_NUM_W-1:0]    kw_num;
    ctc_pkg::kind_t                  kind;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        delim = ctc_pkg::is_delim(s_tdata);
        digit = ctc_pkg::is_digit(s_tdata);

        chars_upd = chars_reg;
        if (len_reg < ctc_pkg::LEN_W'(ctc_pkg::KW_CHARS)) begin
            chars_upd[len_reg[ctc_pkg::KW_IDX_W-1:0]] = s_tdata;
        end
        len_upd       = (len_reg < ctc_pkg::LEN_W'(ctc_pkg::LENGTH_LIMIT)) ?
                        len_reg + 1'b1 : len_reg;
        start_upd     = (len_reg == '0) ? col_reg : start_reg;
        first_dig_upd = (len_reg == '0) ? digit : first_dig_reg;
        all_dig_upd   = all_dig_reg && digit;
        dot_upd       = dot_reg || (s_tdata == ctc_pkg::CH_DOT);
        dod_upd       = dod_reg && (digit || s_tdata == ctc_pkg::CH_DOT);

        chars_aft     = delim ? chars_reg     : chars_upd;
        len_aft       = delim ? len_reg       : len_upd;
        start_aft     = delim ? start_reg     : start_upd;
        first_dig_aft = delim ? first_dig_reg : first_dig_upd;
        all_dig_aft   = delim ? all_dig_reg   : all_dig_upd;
        dot_aft       = delim ? dot_reg       : dot_upd;
        dod_aft       = delim ? dod_reg       : dod_upd;

        kw_hit = 1'b0;
        kw_num = '0;
        for (int k = 0; k < ctc_pkg::KW_COUNT; k++) begin
            if (!kw_hit && len_aft == ctc_pkg::kw_len(k) &&
                chars_aft == ctc_pkg::kw_text(k)) begin
                kw_hit = 1'b1;
                kw_num = ctc_pkg::KW_NUM_W'(k);
            end
        end

        if (kw_hit) begin
            kind = ctc_pkg::KIND_KEYWORD;
        end else if (all_dig_aft) begin
            kind = ctc_pkg::KIND_INTEGER;
        end else if (dod_aft && dot_aft) begin
            kind = ctc_pkg::KIND_REAL;
        end else if (!first_dig_aft) begin
            kind = ctc_pkg::KIND_IDENTIFIER;
        end else begin
            kind = ctc_pkg::KIND_INVALID;
        end

        q_event.has_tok   = delim ? (len_reg != '0) : s_tlast;
        q_event.tok_kind  = kind;
        q_event.tok_start = start_aft;
        q_event.tok_len   = len_aft;
        q_event.tok_kw    = kw_hit ? kw_num : '0;
        q_event.has_op    = ctc_pkg::is_op(s_tdata);
        q_event.op_char   = s_tdata;
        q_event.op_col    = col_reg;
        q_push = accept && (q_event.has_tok || q_event.has_op);

        chars_next     = chars_reg;
        len_next       = len_reg;
        start_next     = start_reg;
        first_dig_next = first_dig_reg;
        all_dig_next   = all_dig_reg;
        dot_next       = dot_reg;
        dod_next       = dod_reg;
        col_next       = col_reg;
        if (accept) begin
            if (delim || s_tlast) begin
                chars_next     = '0;
                len_next       = '0;
                start_next     = '0;
                first_dig_next = 1'b0;
                all_dig_next   = 1'b1;
                dot_next       = 1'b0;
                dod_next       = 1'b1;
            end else begin
                chars_next     = chars_upd;
                len_next       = len_upd;
                start_next     = start_upd;
                first_dig_next = first_dig_upd;
                all_dig_next   = all_dig_upd;
                dot_next       = dot_upd;
                dod_next       = dod_upd;
            end
            if (s_tlast) begin
                col_next = '0;
            end else if (col_reg < ctc_pkg::COL_W'(ctc_pkg::COLUMN_LIMIT - 1)) begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_reg     <= '0;
            len_reg       <= '0;
            start_reg     <= '0;
            first_dig_reg <= 1'b0;
            all_dig_reg   <= 1'b1;
            dot_reg       <= 1'b0;
            dod_reg       <= 1'b1;
            col_reg       <= '0;
        end else begin
            chars_reg     <= chars_next;
            len_reg       <= len_next;
            start_reg     <= start_next;
            first_dig_reg <= first_dig_next;
            all_dig_reg   <= all_dig_next;
            dot_reg       <= dot_next;
            dod_reg       <= dod_next;
            col_reg       <= col_next;
        end
    end

endmodule

>>> design/ctc_queue.sv
// Short event queue between the classifying front end and the result emitter.
// Register-based circular buffer of ctc_pkg::event_t records. Depends on ctc_pkg.
module ctc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ctc_pkg::event_t  push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output ctc_pkg::event_t  q_data
);

    ctc_pkg::event_t                  mem [ctc_pkg::QUEUE_DEPTH];
    logic [ctc_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ctc_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ctc_pkg::Q_CNT_W-1:0]      count_reg, count_next;

    assign full    = count_reg == ctc_pkg::Q_CNT_W'(ctc_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ctc_pkg::Q_PTR_W'((32'(wr_ptr_reg) + 1) % ctc_pkg::QUEUE_DEPTH)
                           : wr_ptr_reg;
        rd_ptr_next = pop ? ctc_pkg::Q_PTR_W'((32'(rd_ptr_reg) + 1) % ctc_pkg::QUEUE_DEPTH)
                          : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !q_valid))
        else $error("queue read while empty");
`endif

endmodule

>>> design/ctc_emit.sv
// Back end: turns queued events into one or two result transactions.
// Owns the output register; the token result goes out before the operator.
// Depends on ctc_pkg.
module ctc_emit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  ctc_pkg::event_t                   q_data,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ctc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [2:0]                        m_tuser,
    output logic                              m_tlast
);

    logic                              valid_reg, valid_next;
    logic                              tok_done_reg, tok_done_next;
    logic [ctc_pkg::M_DATA_W-1:0]      data_reg, data_next;
    ctc_pkg::kind_t                    kind_reg, kind_next;
    logic                              last_reg, last_next;
    logic                              out_free;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next    = valid_reg;
        tok_done_next = tok_done_reg;
        data_next     = data_reg;
        kind_next     = kind_reg;
        last_next     = last_reg;
        pop           = 1'b0;
        if (out_free) begin
            valid_next = 1'b0;
            if (q_valid) begin
                valid_next = 1'b1;
                if (q_data.has_tok && !tok_done_reg) begin
                    kind_next = q_data.tok_kind;
                    data_next = {1'b0, q_data.tok_kw, ctc_pkg::CHAR_W'(0),
                                 q_data.tok_len, q_data.tok_start};
                    last_next = !q_data.has_op;
                    pop       = !q_data.has_op;
                    tok_done_next = q_data.has_op;
                end else begin
                    kind_next = ctc_pkg::KIND_OPERATOR;
                    data_next = {1'b0, ctc_pkg::KW_NUM_W'(0), q_data.op_char,
                                 ctc_pkg::LEN_W'(1), q_data.op_col};
                    last_next = 1'b1;
                    pop       = 1'b1;
                    tok_done_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            tok_done_reg <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            tok_done_reg <= tok_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

`ifndef SYNTHESIS
    a_split_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_done_reg |-> (q_valid && q_data.has_tok && q_data.has_op))
        else $error("token half sent without a pending operator");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                     $stable(m_tuser) && $stable(m_tlast)))
        else $error("result transaction changed while stalled");
`endif

endmodule

>>> design/c_token_classifier_top.sv
// Top level of the C token classifier: front end, event queue and result emitter.
// Depends on ctc_pkg, ctc_front, ctc_queue and ctc_emit.
//
// Usage:
//   Input channel (s_): one source character per transaction in s_tdata; s_tlast
//   marks the final character of a text and resets the column count.
//   Result channel (m_): one result per transaction. m_tuser carries the kind
//   (0 operator, 1 keyword, 2 integer, 3 real, 4 identifier, 5 invalid identifier).
//   m_tlast marks the final result caused by one input character.
//   A result passes through the event queue and then the output register.
//   Throughput: one character per cycle while s_tready is high; a character
//   that causes two results (a token closed by an operator) occupies the emitter for both results.
//   A four-entry event queue absorbs those bursts and receiver stalls; s_tready
//   drops only while the queue is full.
//   Characters that close nothing and are not operators produce no result.
//   Reset (aresetn low, synchronous) empties the queue, drops any result held
//   in the output register and starts a new text at column zero.
//   While m_tready is low the output transaction holds and the front end keeps
//   taking characters until the queue fills.
module c_token_classifier_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] text_byte
    input  logic                              s_tlast,   // end_of_text
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] start_column, [17:10] token_length, [25:18] operator_char,
    // [30:26] keyword_number, [31] zero
    output logic [ctc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic [2:0]                        m_tuser,   // [2:0] kind
    output logic                              m_tlast    // last_of_run
);

    logic             q_full, q_push, q_pop, q_valid;
    ctc_pkg::event_t  push_event, head_event;

    ctc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_event  (push_event)
    );

    ctc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_event),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (head_event)
    );

    ctc_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (head_event),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> tb/sv/ctc_token_check.sv
// Checker for the C token classifier: watches both stream channels, predicts the
// token and operator results of every accepted character and compares them in order.
// Depends on ctc_pkg for widths, character codes and the kind encoding.
module ctc_token_check
    import ctc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,    // [7:0] text_byte
    input  logic                s_tlast,    // end_of_text
    input  logic                m_tvalid,
    input  logic                m_tready,
    // [9:0] start_column, [17:10] token_length, [25:18] operator_char,
    // [30:26] keyword_number, [31] zero
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic [2:0]          m_tuser,    // [2:0] kind
    input  logic                m_tlast,    // last_of_run
    output int                  fail_count,
    output int                  tokens_due
);

    typedef struct packed {
        logic [2:0]          kind;
        logic                pad;
        logic [KW_NUM_W-1:0] kw_num;
        logic [CHAR_W-1:0]   op_char;
        logic [LEN_W-1:0]    tok_len;
        logic [COL_W-1:0]    col;
        logic                last;
    } token_rec_t;

    token_rec_t        token_q[$];
    token_rec_t        got;
    token_rec_t        want;

    logic [CHAR_W-1:0] tok_chars [KW_CHARS];
    int unsigned       tok_len;
    int unsigned       tok_start;
    int unsigned       col_now;
    bit                all_dig;
    bit                dig_dot;
    bit                saw_dot;
    bit                first_dig;
    bit                past_table;

    initial begin
        fail_count = 0;
        tokens_due = 0;
    end

    function automatic string kw_word(input int idx);
        case (idx)
            0:  return "auto";
            1:  return "break";
            2:  return "case";
            3:  return "char";
            4:  return "const";
            5:  return "continue";
            6:  return "default";
            7:  return "do";
            8:  return "double";
            9:  return "else";
            10: return "enum";
            11: return "extern";
            12: return "float";
            13: return "for";
            14: return "goto";
            15: return "if";
            16: return "int";
            17: return "long";
            18: return "register";
            19: return "return";
            20: return "short";
            21: return "signed";
            22: return "sizeof";
            23: return "static";
            24: return "struct";
            25: return "switch";
            26: return "typedef";
            27: return "union";
            28: return "unsigned";
            29: return "void";
            30: return "volatile";
            default: return "while";
        endcase
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return c inside {CH_SPACE, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_COMMA,
                         CH_SEMI, CH_GT, CH_LT, CH_EQ, CH_LPAREN, CH_RPAREN,
                         CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE};
    endfunction

    function automatic bit is_opchar(input logic [7:0] c);
        return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_GT, CH_LT, CH_EQ};
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_token();
        int i;
        for (i = 0; i < KW_CHARS; i++) begin
            tok_chars[i] = '0;
        end
        tok_len    = 0;
        tok_start  = 0;
        all_dig    = 1'b1;
        dig_dot    = 1'b1;
        saw_dot    = 1'b0;
        first_dig  = 1'b0;
        past_table = 1'b0;
    endtask

    task automatic close_token();
        token_rec_t rec;
        string      w;
        int         i;
        int         j;
        bit         hit;
        bit         same;
        hit = 1'b0;
        rec = '0;
        if (!past_table && tok_len <= KW_CHARS) begin
            for (i = 0; i < KW_COUNT && !hit; i++) begin
                w = kw_word(i);
                if (w.len() == tok_len) begin
                    same = 1'b1;
                    for (j = 0; j < w.len(); j++) begin
                        if (tok_chars[j] != w[j]) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        hit = 1'b1;
                        rec.kw_num = KW_NUM_W'(i);
                    end
                end
            end
        end
        if (hit) begin
            rec.kind = KIND_KEYWORD;
        end else if (all_dig) begin
            rec.kind = KIND_INTEGER;
        end else if (dig_dot && saw_dot) begin
            rec.kind = KIND_REAL;
        end else if (!first_dig) begin
            rec.kind = KIND_IDENTIFIER;
        end else begin
            rec.kind = KIND_INVALID;
        end
        rec.col     = COL_W'(tok_start);
        rec.tok_len = LEN_W'(tok_len);
        token_q.push_back(rec);
    endtask

    task automatic absorb_char(input logic [7:0] c, input logic eot);
        token_rec_t rec;
        int         base;
        base = token_q.size();
        if (is_sep(c)) begin
            if (tok_len > 0) begin
                close_token();
            end
            if (is_opchar(c)) begin
                rec         = '0;
                rec.kind    = KIND_OPERATOR;
                rec.col     = COL_W'(col_now);
                rec.tok_len = LEN_W'(1);
                rec.op_char = c;
                token_q.push_back(rec);
            end
            clear_token();
        end else begin
            if (tok_len == 0 && !past_table) begin
                tok_start = col_now;
                first_dig = is_num(c);
            end
            if (tok_len < KW_CHARS && !past_table) begin
                tok_chars[tok_len] = c;
            end else begin
                past_table = 1'b1;
            end
            if (tok_len < LENGTH_LIMIT) begin
                tok_len++;
            end
            if (!is_num(c)) begin
                all_dig = 1'b0;
            end
            if (c == CH_DOT) begin
                saw_dot = 1'b1;
            end else if (!is_num(c)) begin
                dig_dot = 1'b0;
            end
            if (eot) begin
                close_token();
                clear_token();
            end
        end
        if (eot) begin
            col_now = 0;
        end else if (col_now < COLUMN_LIMIT - 1) begin
            col_now++;
        end
        if (token_q.size() > base) begin
            token_q[token_q.size() - 1].last = 1'b1;
        end
    endtask

    task automatic report(input string what, input token_rec_t w, input token_rec_t g);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s: expected kind %0d col %0d len %0d op %02h kw %0d last %b pad %b",
                     what, w.kind, w.col, w.tok_len, w.op_char, w.kw_num, w.last, w.pad);
            $display("    got kind %0d col %0d len %0d op %02h kw %0d last %b pad %b",
                     g.kind, g.col, g.tok_len, g.op_char, g.kw_num, g.last, g.pad);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_token();
            col_now = 0;
            token_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_char(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata, m_tlast};
                if (token_q.size() == 0) begin
                    report("result with no token pending", '0, got);
                end else begin
                    want = token_q.pop_front();
                    if (got !== want) begin
                        report("token mismatch", want, got);
                    end
                end
            end
        end
        tokens_due <= token_q.size();
    end

endmodule

>>> tb/sv/tb_c_token_classifier_top.sv
// Testbench top for the C token classifier: drives source text with random idling
// on both channels and gives the verdict from the checker's failure count and a run watchdog.
// Depends on ctc_pkg, c_token_classifier_top and ctc_token_check.
module tb_c_token_classifier_top;
    import ctc_pkg::*;

    localparam int LIMIT      = 1_200_000;
    localparam int BULK_CHARS = 1400;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [7:0]          s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;
    logic [2:0]          m_tuser;
    logic                m_tlast;

    int                  fail_count;
    int                  tokens_due;
    int                  cycles      = 0;
    int                  ready_hold  = 0;
    int                  sent        = 0;
    int                  line_len    = 0;
    int                  line_target = 40;
    bit                  calm        = 1'b0;
    bit                  long_done   = 1'b0;

    logic [7:0] seps [16] = '{CH_SPACE, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_COMMA,
                              CH_SEMI, CH_GT, CH_LT, CH_EQ, CH_LPAREN, CH_RPAREN,
                              CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE};

    c_token_classifier_top i_dut (.*);

    ctc_token_check i_check (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (calm) begin
            m_tready   <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) != 0) begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 3);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) begin
            return 8'h61 + 8'(r);
        end else if (r < 52) begin
            return 8'h41 + 8'(r - 26);
        end
        return 8'h5F;
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_alnum();
        return ($urandom_range(0, 2) == 0) ? pick_digit() : pick_letter();
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        line_len = eot ? 0 : line_len + 1;
    endtask

    task automatic send_str(input string s, input bit eot_last);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_char(s[i], eot_last && i == s.len() - 1);
        end
    endtask

    // end the line once it reaches its target length
    task automatic flow_char(input logic [7:0] c);
        bit eot;
        eot = line_len + 1 >= line_target;
        send_char(c, eot);
        if (eot) begin
            line_target = $urandom_range(3, 120);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tokens_due != 0);
    endtask

    task automatic random_token();
        logic [7:0] word_q[$];
        kw_chars_t  txt;
        int         n;
        int         idx;
        int         i;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                idx = $urandom_range(0, KW_COUNT - 1);
                txt = kw_text(idx);
                n   = int'(kw_len(idx));
                for (i = 0; i < n; i++) begin
                    word_q.push_back(txt[i]);
                end
                case ($urandom_range(0, 7))
                    0: void'(word_q.pop_back());
                    1: word_q.push_back(pick_letter());
                    2: word_q[$urandom_range(0, n - 1)] ^= 8'h20;
                    default: ;
                endcase
            end
            3: begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    word_q.push_back(pick_digit());
                end
            end
            4: begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    word_q.push_back(($urandom_range(0, 2) == 0) ? CH_DOT : pick_digit());
                end
                word_q[$urandom_range(0, n - 1)] = CH_DOT;
            end
            5, 6: begin
                word_q.push_back(pick_letter());
                n = $urandom_range(0, 8);
                for (i = 0; i < n; i++) begin
                    word_q.push_back(pick_alnum());
                end
            end
            7: begin
                word_q.push_back(pick_digit());
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    word_q.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : pick_alnum());
                end
            end
            8: begin
                n = $urandom_range(1, 5);
                for (i = 0; i < n; i++) begin
                    word_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            default: ;
        endcase
        for (i = 0; i < word_q.size(); i++) begin
            flow_char(word_q[i]);
        end
        flow_char(seps[$urandom_range(0, 15)]);
        if ($urandom_range(0, 3) == 0) begin
            flow_char(seps[$urandom_range(0, 15)]);
        end
    endtask

    // saturate the column count and the token length within one line
    task automatic long_line();
        int i;
        line_target = line_len + $urandom_range(1100, 1200);
        for (i = 0; i < 300; i++) begin
            flow_char(pick_letter());
        end
        flow_char(CH_SPACE);
        for (i = 0; i < 270; i++) begin
            flow_char(pick_digit());
        end
        flow_char(CH_PLUS);
        while (line_len != 0) begin
            random_token();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_str("auto+", 1'b0);
        send_str("12.5*", 1'b0);
        send_str("9a-", 1'b0);
        send_str("77/", 1'b0);
        send_str(" <>=", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        send_str("x;", 1'b1);
        send_str("y=", 1'b1);
        drain();

        line_target = $urandom_range(3, 120);
        while (sent < BULK_CHARS) begin
            if ($urandom_range(0, 39) == 0) begin
                calm <= ~calm;
            end
            random_token();
            if (!long_done && sent > BULK_CHARS / 8) begin
                drain();
                long_line();
                long_done = 1'b1;
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
